// File: rtl/core/bcd_pkg.sv
// Shared types, format codes and arithmetic helpers for the texture block decoder.
`default_nettype none
package bcd_pkg;

  // Block format codes held in the format register.
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // Endpoints widened and the palette numerators, before the divisions.
  typedef struct packed {
    logic [1:0]        fmt;
    logic              three;   // BC1 three-colour mode
    logic              seven;   // eight-entry alpha palette
    logic [2:0][7:0]   c0;      // red, green, blue of endpoint 0
    logic [2:0][7:0]   c1;
    logic [2:0][9:0]   s2;      // numerator of colour entry 2
    logic [2:0][9:0]   s3;      // numerator of colour entry 3
    logic [7:0]        a0;
    logic [7:0]        a1;
    logic [5:0][10:0]  asum;    // numerators of alpha entries 2..7
    logic [63:0]       ah;
    logic [31:0]       idx;
  } sum_t;

  // Finished palettes plus the per-pixel selectors.
  typedef struct packed {
    logic [1:0]        fmt;
    logic [3:0][31:0]  pal;
    logic [7:0][7:0]   apal;
    logic [63:0]       ah;
    logic [31:0]       idx;
  } pal_t;

  // RGB565 to three 8-bit channels by bit replication.
  function automatic logic [2:0][7:0] widen565(input logic [15:0] v);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    logic [2:0][7:0] ch;
    r = v[15:11];
    g = v[10:5];
    b = v[4:0];
    ch[0] = {r, r[4:2]};
    ch[1] = {g, g[5:4]};
    ch[2] = {b, b[4:2]};
    return ch;
  endfunction

  // Division by three through a reciprocal, exact for x below 768.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // Division by five, exact for x up to 1275.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  // Division by seven, exact for x up to 1785.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/bc_texture_block_decoder.sv
// Top level of the BC1/BC2/BC3 texture block decoder.
// A block's first row passes the sum, palette, block and row output registers.
// The four rows follow on consecutive cycles when the output is not stalled.
// Rows leave one per cycle unless stalled; the next block enters as row 3 is sent.
// Reset (rst, synchronous) empties the pipeline and sets the block format to BC1.
`default_nettype none
module bc_texture_block_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  // Format register write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   block_format,
  // Compressed block input channel.
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [63:0]  alpha_half,
  input  wire logic [63:0]  colour_half,
  // Decoded row output channel.
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        row_number,
  output logic [31:0]       texel_zero,
  output logic [31:0]       texel_one,
  output logic [31:0]       texel_two,
  output logic [31:0]       texel_three,
  output logic              final_row
);

  // The format register takes a write in every cycle. The format travels with
  // each block down the pipeline, captured when its input transaction occurs.
  logic [1:0] fmt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= bcd_pkg::FMT_BC1;
    end else if (cfg_valid) begin
      fmt <= block_format;
    end
  end

  // Stage one widens the endpoints and forms the palette numerators; stage two
  // divides them by the constants; the emitter buffers a block and sends rows.
  // Each stage accepts whenever its register is empty or draining, so a stall
  // on the output backs up through the stages without losing a transaction.
  logic          s1_valid;
  logic          s1_ready;
  bcd_pkg::sum_t s1_data;
  logic          s2_valid;
  logic          s2_ready;
  bcd_pkg::pal_t s2_data;

  bcd_sum_stage u_sum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .alpha_half  (alpha_half),
    .colour_half (colour_half),
    .fmt         (fmt),
    .out_valid   (s1_valid),
    .out_ready   (s1_ready),
    .out_data    (s1_data)
  );

  bcd_palette_stage u_palette (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  bcd_row_emitter u_rows (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s2_valid),
    .in_ready    (s2_ready),
    .in_data     (s2_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_number  (row_number),
    .texel_zero  (texel_zero),
    .texel_one   (texel_one),
    .texel_two   (texel_two),
    .texel_three (texel_three),
    .final_row   (final_row)
  );

endmodule
`default_nettype wire

// File: rtl/core/bcd_sum_stage.sv
// First pipeline stage: endpoint widening, mode decisions and palette numerators.
`default_nettype none
module bcd_sum_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [63:0]  alpha_half,
  input  wire logic [63:0]  colour_half,
  input  wire logic [1:0]   fmt,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bcd_pkg::sum_t     out_data
);

  bcd_pkg::sum_t data_next;
  logic [2:0] wa [6];
  logic [2:0] wb [6];

  always_comb begin
    data_next.fmt   = fmt;
    data_next.c0    = bcd_pkg::widen565(colour_half[15:0]);
    data_next.c1    = bcd_pkg::widen565(colour_half[31:16]);
    data_next.three = (fmt != bcd_pkg::FMT_BC2) && (fmt != bcd_pkg::FMT_BC3) &&
                      (colour_half[15:0] <= colour_half[31:16]);
    for (int k = 0; k < 3; k++) begin
      if (data_next.three) begin
        data_next.s2[k] = 10'(data_next.c0[k]) + 10'(data_next.c1[k]);
      end else begin
        data_next.s2[k] = {1'b0, data_next.c0[k], 1'b0} + 10'(data_next.c1[k]);
      end
      data_next.s3[k] = 10'(data_next.c0[k]) + {1'b0, data_next.c1[k], 1'b0};
    end
    data_next.a0    = alpha_half[7:0];
    data_next.a1    = alpha_half[15:8];
    data_next.seven = alpha_half[7:0] > alpha_half[15:8];
    for (int j = 0; j < 6; j++) begin
      wb[j] = 3'(j + 1);
      if (data_next.seven) begin
        wa[j] = 3'(6 - j);
      end else if (j < 4) begin
        wa[j] = 3'(4 - j);
      end else begin
        wa[j] = 3'd0;
      end
      data_next.asum[j] = 11'(11'(data_next.a0) * 11'(wa[j])) +
                          11'(11'(data_next.a1) * 11'(wb[j]));
    end
    data_next.ah  = alpha_half;
    data_next.idx = colour_half[63:32];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bcd_palette_stage.sv
// Second pipeline stage: constant divisions that finish the colour and alpha palettes.
`default_nettype none
module bcd_palette_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bcd_pkg::sum_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bcd_pkg::pal_t      out_data
);

  bcd_pkg::pal_t data_next;
  logic [2:0][7:0] m2;
  logic [2:0][7:0] m3;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (in_data.three) begin
        m2[k] = in_data.s2[k][8:1];
        m3[k] = 8'd0;
      end else begin
        m2[k] = bcd_pkg::div3(in_data.s2[k]);
        m3[k] = bcd_pkg::div3(in_data.s3[k]);
      end
    end
    data_next.fmt    = in_data.fmt;
    data_next.pal[0] = {8'hff, in_data.c0[2], in_data.c0[1], in_data.c0[0]};
    data_next.pal[1] = {8'hff, in_data.c1[2], in_data.c1[1], in_data.c1[0]};
    data_next.pal[2] = {8'hff, m2[2], m2[1], m2[0]};
    data_next.pal[3] = {(in_data.three ? 8'h00 : 8'hff), m3[2], m3[1], m3[0]};
    data_next.apal[0] = in_data.a0;
    data_next.apal[1] = in_data.a1;
    for (int j = 0; j < 6; j++) begin
      if (in_data.seven) begin
        data_next.apal[j + 2] = bcd_pkg::div7(in_data.asum[j]);
      end else if (j < 4) begin
        data_next.apal[j + 2] = bcd_pkg::div5(in_data.asum[j]);
      end else if (j == 4) begin
        data_next.apal[j + 2] = 8'd0;
      end else begin
        data_next.apal[j + 2] = 8'd255;
      end
    end
    data_next.ah  = in_data.ah;
    data_next.idx = in_data.idx;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bcd_row_emitter.sv
// Final stage: holds one decoded block and sends it out as four pixel rows.
`default_nettype none
module bcd_row_emitter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bcd_pkg::pal_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         row_number,
  output logic [31:0]        texel_zero,
  output logic [31:0]        texel_one,
  output logic [31:0]        texel_two,
  output logic [31:0]        texel_three,
  output logic               final_row
);

  bcd_pkg::pal_t blk;
  logic          blk_valid;
  logic [1:0]    row;
  logic          emit;
  logic [7:0]    row_idx;
  logic [15:0]   row_a3;
  logic [11:0]   row_a5;
  logic [1:0]    ci   [4];
  logic [2:0]    ai   [4];
  logic [3:0]    nib  [4];
  logic [31:0]   px   [4];

  assign emit     = blk_valid && (!out_valid || out_ready);
  assign in_ready = !blk_valid || (emit && (row == 2'd3));

  always_comb begin
    row_idx = blk.idx[{row, 3'b000} +: 8];
    row_a3  = blk.ah[{row, 4'b0000} +: 16];
    row_a5  = blk.ah[6'd16 + 6'(row) * 6'd12 +: 12];
    for (int c = 0; c < 4; c++) begin
      ci[c]  = row_idx[2 * c +: 2];
      nib[c] = row_a3[4 * c +: 4];
      ai[c]  = row_a5[3 * c +: 3];
      px[c]  = blk.pal[ci[c]];
      if (blk.fmt == bcd_pkg::FMT_BC2) begin
        px[c][31:24] = {nib[c], nib[c]};
      end else if (blk.fmt == bcd_pkg::FMT_BC3) begin
        px[c][31:24] = blk.apal[ai[c]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      row       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        blk_valid <= in_valid;
      end
      if (emit) begin
        row       <= row + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      blk <= in_data;
    end
    if (emit) begin
      row_number  <= row;
      texel_zero  <= px[0];
      texel_one   <= px[1];
      texel_two   <= px[2];
      texel_three <= px[3];
      final_row   <= (row == 2'd3);
    end
  end

endmodule
`default_nettype wire
